### src/assert_macros.svh
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, held off during reset
`define ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, held off during reset
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### src/shamp_pkg.sv
package shamp_pkg;

   localparam int WordWidth = 32;
   localparam int FixedWords = 16;
   localparam int LaneWords = 3;

   typedef logic [WordWidth-1:0] word_type;
   typedef logic [2:0] csr_type;

   typedef struct packed {
      word_type mid_a;
      word_type mid_b;
      word_type mid_c;
      word_type mid_d;
      word_type mid_e;
      word_type mid_f;
      word_type mid_g;
      word_type mid_h;
      word_type msg_w0;
      word_type msg_w1;
      word_type msg_w2;
   } req_type;

   typedef struct packed {
      word_type   pre_word;
      logic [4:0] word_index;
      logic       last_word;
   } rsp_type;

   // working variables in standard rotated form plus the three message words
   typedef struct packed {
      word_type a;
      word_type b;
      word_type c;
      word_type d;
      word_type e;
      word_type f;
      word_type g;
      word_type h;
      word_type w0;
      word_type w1;
      word_type w2;
   } state_type;

   typedef struct packed {
      logic [FixedWords-1:0][WordWidth-1:0] fixed;
      logic [LaneWords-1:0][WordWidth-1:0]  lane;
   } bank_type;

   localparam word_type K0 = 32'h428A2F98;
   localparam word_type K1 = 32'h71374491;
   localparam word_type K2 = 32'hB5C0FBCF;
   localparam word_type K3 = 32'hE9B5DBA5;
   localparam word_type D_OFFSET = 32'hB956C25B;
   localparam word_type W17_CONST = 32'h01100000;
   localparam word_type W19_CONST = 32'h11002000;
   localparam word_type W31_CONST = 32'h00000280;
   localparam word_type B_OFFSET = 32'h923F82A4;
   localparam word_type C_OFFSET = 32'h59F111F1;
   localparam word_type A_OFFSET = 32'h5F395B94;
   localparam word_type W16_OFFSET = 32'hE49B69C1;
   localparam word_type W17_OFFSET = 32'hEFBE4786;

   function automatic word_type big_s0(word_type x);
      return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
   endfunction

   function automatic word_type big_s1(word_type x);
      return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
   endfunction

   function automatic word_type sml_s0(word_type x);
      return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
   endfunction

   function automatic word_type sml_s1(word_type x);
      return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
   endfunction

   function automatic word_type choose(word_type x, word_type y, word_type z);
      return z ^ (x & (y ^ z));
   endfunction

   function automatic word_type major(word_type x, word_type y, word_type z);
      return (y & z) | (x & (y | z));
   endfunction

endpackage

### src/shamp_stream_if.sv
interface shamp_stream_if #(parameter type payload_type = logic) ();
   logic        valid;
   logic        ready;
   payload_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

### src/sha256_midstate_precalc.sv
// SHA-256 midstate precalculation. Each request word (midstate plus the first three
// message words of the second block) yields a run of 19, 22 or 28 result words, one per
// cycle unless rsp_bus stalls, for a vector count of 0-1, 2-3 or 4-7: sixteen fixed
// words, then A, E and the W19 partial in one, two or four bit-flipped variants;
// last_word marks the end of the run. The single result word port sets the rate, and
// requests are taken while the previous run drains. The first word passes the input
// register, three round stages, the final round stage and the output register. Write
// vector_count only while the block is idle.
`include "assert_macros.svh"

module sha256_midstate_precalc
   import shamp_pkg::*;
(
   input  logic clock,
   input  logic reset,
   shamp_stream_if.sink   req_bus,
   shamp_stream_if.source rsp_bus,
   shamp_stream_if.sink   csr_bus
);

   shamp_stream_if #(.payload_type(state_type)) st0 ();
   shamp_stream_if #(.payload_type(state_type)) st1 ();
   shamp_stream_if #(.payload_type(state_type)) st2 ();
   shamp_stream_if #(.payload_type(state_type)) st3 ();
   shamp_stream_if #(.payload_type(bank_type))  bank_bus ();

   req_type    req;
   logic       req_valid_ff;
   state_type  req_data_ff;
   state_type  req_data_in;
   csr_type    vector_count_ff;
   logic [1:0] lane_shift;
   logic [4:0] word_total;

   assign req = req_bus.data;
   assign req_bus.ready = !req_valid_ff || st0.ready;
   assign csr_bus.ready = 1'b1;

   always_comb begin
      req_data_in.a = req.mid_a;
      req_data_in.b = req.mid_b;
      req_data_in.c = req.mid_c;
      req_data_in.d = req.mid_d;
      req_data_in.e = req.mid_e;
      req_data_in.f = req.mid_f;
      req_data_in.g = req.mid_g;
      req_data_in.h = req.mid_h;
      req_data_in.w0 = req.msg_w0;
      req_data_in.w1 = req.msg_w1;
      req_data_in.w2 = req.msg_w2;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         vector_count_ff <= 3'd1;
      end else begin
         if (req_bus.ready) begin
            req_valid_ff <= req_bus.valid;
         end
         if (csr_bus.valid) begin
            vector_count_ff <= csr_bus.data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_bus.valid && req_bus.ready) begin
         req_data_ff <= req_data_in;
      end
   end

   assign st0.valid = req_valid_ff;
   assign st0.data = req_data_ff;

   // lanes: zero or one -> 1, two or three -> 2, four and up -> 4
   assign lane_shift = vector_count_ff[2] ? 2'd2 : (vector_count_ff[1] ? 2'd1 : 2'd0);
   assign word_total = 5'd16 + (5'd3 << lane_shift);

   shamp_round u_round0 (
      .clock   (clock),
      .reset   (reset),
      .k       (K0),
      .w       (st0.data.w0),
      .in_bus  (st0),
      .out_bus (st1)
   );

   shamp_round u_round1 (
      .clock   (clock),
      .reset   (reset),
      .k       (K1),
      .w       (st1.data.w1),
      .in_bus  (st1),
      .out_bus (st2)
   );

   shamp_round u_round2 (
      .clock   (clock),
      .reset   (reset),
      .k       (K2),
      .w       (st2.data.w2),
      .in_bus  (st2),
      .out_bus (st3)
   );

   shamp_final u_final (
      .clock   (clock),
      .reset   (reset),
      .in_bus  (st3),
      .out_bus (bank_bus)
   );

   shamp_serializer u_serializer (
      .clock      (clock),
      .reset      (reset),
      .lane_shift (lane_shift),
      .word_total (word_total),
      .bank_bus   (bank_bus),
      .rsp_bus    (rsp_bus)
   );

   // the run ends exactly at the word count set by vector_count
   `ASSERT_SAME(a_last_at_total, clock, reset, rsp_bus.valid && rsp_bus.data.last_word, rsp_bus.data.word_index == word_total - 5'd1, "last word at wrong index")

   // inside a run the next word follows at once with the next index
   `ASSERT_NEXT(a_run_continues, clock, reset, rsp_bus.valid && rsp_bus.ready && !rsp_bus.data.last_word, rsp_bus.valid && rsp_bus.data.word_index == $past(rsp_bus.data.word_index) + 5'd1, "run broken")

endmodule

### src/shamp_round.sv
module shamp_round
   import shamp_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  word_type k,
   input  word_type w,
   shamp_stream_if.sink   in_bus,
   shamp_stream_if.source out_bus
);

   logic      valid_ff;
   state_type data_ff;
   state_type data_in;
   state_type cur;
   word_type  t1;
   word_type  t2;

   assign cur = in_bus.data;
   assign in_bus.ready = !valid_ff || out_bus.ready;

   always_comb begin
      t1 = cur.h + big_s1(cur.e) + choose(cur.e, cur.f, cur.g) + k + w;
      t2 = big_s0(cur.a) + major(cur.a, cur.b, cur.c);
      data_in = cur;
      data_in.a = t1 + t2;
      data_in.b = cur.a;
      data_in.c = cur.b;
      data_in.d = cur.c;
      data_in.e = cur.d + t1;
      data_in.f = cur.e;
      data_in.g = cur.f;
      data_in.h = cur.g;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_bus.ready) begin
         valid_ff <= in_bus.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_bus.valid && in_bus.ready) begin
         data_ff <= data_in;
      end
   end

   assign out_bus.valid = valid_ff;
   assign out_bus.data = data_ff;

endmodule

### src/shamp_final.sv
module shamp_final
   import shamp_pkg::*;
(
   input  logic clock,
   input  logic reset,
   shamp_stream_if.sink   in_bus,
   shamp_stream_if.source out_bus
);

   logic      valid_ff;
   bank_type  bank_ff;
   bank_type  bank_in;
   state_type s;
   word_type  t;
   word_type  w16;
   word_type  w17;

   assign s = in_bus.data;
   assign in_bus.ready = !valid_ff || out_bus.ready;

   // after three rounds: a..c hold the new a words, e..g the new e words,
   // d the original a and h the original e
   always_comb begin
      t = s.h + big_s1(s.e) + choose(s.e, s.f, s.g) + K3;
      w16 = s.w0 + sml_s0(s.w1);
      w17 = s.w1 + W17_CONST + sml_s0(s.w2);
      bank_in.fixed[0] = s.e;
      bank_in.fixed[1] = s.f;
      bank_in.fixed[2] = s.g + D_OFFSET;
      bank_in.fixed[3] = s.a;
      bank_in.fixed[4] = s.b;
      bank_in.fixed[5] = s.c;
      bank_in.fixed[6] = w16;
      bank_in.fixed[7] = w17;
      bank_in.fixed[8] = s.w2 + sml_s1(w16);
      bank_in.fixed[9] = W31_CONST + sml_s0(w16);
      bank_in.fixed[10] = w16 + sml_s0(w17);
      bank_in.fixed[11] = s.e + B_OFFSET;
      bank_in.fixed[12] = s.f + C_OFFSET;
      bank_in.fixed[13] = s.d + A_OFFSET;
      bank_in.fixed[14] = w16 + W16_OFFSET;
      bank_in.fixed[15] = w17 + W17_OFFSET;
      bank_in.lane[0] = s.d + t;
      bank_in.lane[1] = t + big_s0(s.a) + major(s.a, s.b, s.c);
      bank_in.lane[2] = sml_s1(w17) + W19_CONST;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_bus.ready) begin
         valid_ff <= in_bus.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_bus.valid && in_bus.ready) begin
         bank_ff <= bank_in;
      end
   end

   assign out_bus.valid = valid_ff;
   assign out_bus.data = bank_ff;

endmodule

### src/shamp_serializer.sv
module shamp_serializer
   import shamp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic [1:0] lane_shift,
   input  logic [4:0] word_total,
   shamp_stream_if.sink   bank_bus,
   shamp_stream_if.source rsp_bus
);

   bank_type   bank;
   logic       load;
   logic       last;
   logic [4:0] cnt_ff;
   logic [4:0] cnt_in;
   logic [4:0] lane_pos;
   logic [1:0] base;
   logic [1:0] variant;
   word_type   word_sel;
   logic       rsp_valid_ff;
   rsp_type    rsp_data_ff;

   assign bank = bank_bus.data;
   assign load = bank_bus.valid && (!rsp_valid_ff || rsp_bus.ready);
   assign last = cnt_ff == word_total - 5'd1;
   assign cnt_in = last ? 5'd0 : cnt_ff + 5'd1;
   assign lane_pos = cnt_ff - 5'd16;
   assign bank_bus.ready = load && last;

   always_comb begin
      case (lane_shift)
         2'd1: begin
            base = lane_pos[2:1];
            variant = {1'b0, lane_pos[0]};
         end
         2'd2: begin
            base = lane_pos[3:2];
            variant = lane_pos[1:0];
         end
         default: begin
            base = lane_pos[1:0];
            variant = 2'd0;
         end
      endcase
      if (!cnt_ff[4]) begin
         word_sel = bank.fixed[cnt_ff[3:0]];
      end else begin
         // variant 1 flips bit 31, variant 2 bit 30, variant 3 both
         word_sel = bank.lane[base] ^ {variant[0], variant[1], 30'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 5'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (load) begin
            cnt_ff <= cnt_in;
         end
         if (load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_data_ff.pre_word <= word_sel;
         rsp_data_ff.word_index <= cnt_ff;
         rsp_data_ff.last_word <= last;
      end
   end

   assign rsp_bus.valid = rsp_valid_ff;
   assign rsp_bus.data = rsp_data_ff;

endmodule

### tb/sv/sha256_midstate_precalc_tb.sv
`timescale 1ns / 1ps

module sha256_midstate_precalc_tb;
   import shamp_pkg::*;

   localparam int StallLimit = 2000;
   localparam int RandomItems = 500;
   localparam int DrainCycles = 12;

   typedef struct {
      int       lanes_cfg;   // -1 keeps the current setting
      req_type  hdr;
      bit       typed;
      word_type mid_off;     // known value of the midstate-offset word
   } dir_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic     req_valid = 1'b0;
   req_type  req_data = '0;
   logic     rsp_take = 1'b0;
   logic     csr_valid = 1'b0;
   csr_type  csr_data = '0;

   shamp_stream_if #(.payload_type(req_type)) req_if ();
   shamp_stream_if #(.payload_type(rsp_type)) rsp_if ();
   shamp_stream_if #(.payload_type(csr_type)) csr_if ();

   assign req_if.valid = req_valid;
   assign req_if.data = req_data;
   assign rsp_if.ready = rsp_take;
   assign csr_if.valid = csr_valid;
   assign csr_if.data = csr_data;

   sha256_midstate_precalc u_top (
      .clock(clock),
      .reset(reset),
      .req_bus(req_if),
      .rsp_bus(rsp_if),
      .csr_bus(csr_if)
   );

   always #2 clock = ~clock;

   csr_type lane_setting = 3'd1;
   rsp_type expected_words[$];
   rsp_type run_buf[$];
   int      errors = 0;
   int      stall_left = 0;
   int      quiet_cycles = 0;
   bit      calm = 1'b0;

   dir_row_type dir_rows[15] = '{
      '{-1, {11{32'h00000000}}, 1'b1, 32'h5F395B94},
      '{-1, {11{32'hFFFFFFFF}}, 1'b1, 32'h5F395B93},
      '{0, {11{32'h00000000}}, 1'b1, 32'h5F395B94},
      '{0, {11{32'hFFFFFFFF}}, 1'b0, 32'h0},
      '{2, {11{32'h00000000}}, 1'b0, 32'h0},
      '{2, {11{32'hAAAAAAAA}}, 1'b0, 32'h0},
      '{3, {11{32'h55555555}}, 1'b0, 32'h0},
      '{4, {11{32'hFFFFFFFF}}, 1'b1, 32'h5F395B93},
      '{4, {11{32'h80000000}}, 1'b1, 32'hDF395B94},
      '{5, {11{32'h00000001}}, 1'b0, 32'h0},
      '{6, {32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A, 32'h510E527F,
            32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19, 32'h4A5E1E4B, 32'h495FAB29,
            32'h1D00FFFF}, 1'b0, 32'h0},
      '{7, {11{32'h00000000}}, 1'b1, 32'h5F395B94},
      '{7, {11{32'hFFFFFFFF}}, 1'b0, 32'h0},
      '{1, {32'hFFFFFFFF, {10{32'h00000000}}}, 1'b1, 32'h5F395B93},
      '{1, {32'h00000000, {7{32'hFFFFFFFF}}, 32'h80000000, 32'h7FFFFFFF, 32'h00000001},
         1'b0, 32'h0}
   };

   function automatic word_type ror(word_type x, int n);
      return (x >> n) | (x << (32 - n));
   endfunction

   function automatic word_type sum0(word_type x);
      return ror(x, 2) ^ ror(x, 13) ^ ror(x, 22);
   endfunction

   function automatic word_type sum1(word_type x);
      return ror(x, 6) ^ ror(x, 11) ^ ror(x, 25);
   endfunction

   function automatic word_type sig0(word_type x);
      return ror(x, 7) ^ ror(x, 18) ^ (x >> 3);
   endfunction

   function automatic word_type sig1(word_type x);
      return ror(x, 17) ^ ror(x, 19) ^ (x >> 10);
   endfunction

   function automatic word_type pick_bits(word_type x, word_type y, word_type z);
      return z ^ (x & (y ^ z));
   endfunction

   function automatic word_type vote_bits(word_type x, word_type y, word_type z);
      return (y & z) | (x & (y | z));
   endfunction

   // fills run_buf with the words one header produces under lane_setting
   function automatic void precalc_run(req_type r);
      word_type vals[28];
      word_type tail[3];
      word_type h1, h2, d1, g1, g2, c1, f1, f2, b1, t3, a_new, e_new;
      word_type w16, w17;
      rsp_type item;
      int lanes;
      int n;
      h1 = r.mid_h + sum1(r.mid_e) + pick_bits(r.mid_e, r.mid_f, r.mid_g) + K0 + r.msg_w0;
      d1 = r.mid_d + h1;
      h2 = h1 + sum0(r.mid_a) + vote_bits(r.mid_a, r.mid_b, r.mid_c);
      g1 = r.mid_g + sum1(d1) + pick_bits(d1, r.mid_e, r.mid_f) + K1 + r.msg_w1;
      c1 = r.mid_c + g1;
      g2 = g1 + sum0(h2) + vote_bits(h2, r.mid_a, r.mid_b);
      f1 = r.mid_f + sum1(c1) + pick_bits(c1, d1, r.mid_e) + K2 + r.msg_w2;
      b1 = r.mid_b + f1;
      f2 = f1 + sum0(g2) + vote_bits(g2, h2, r.mid_a);
      t3 = sum1(b1) + pick_bits(b1, c1, d1) + K3;
      e_new = r.mid_e + t3 + sum0(f2) + vote_bits(f2, g2, h2);
      a_new = r.mid_a + r.mid_e + t3;
      w16 = r.msg_w0 + sig0(r.msg_w1);
      w17 = r.msg_w1 + W17_CONST + sig0(r.msg_w2);
      vals[0] = b1;
      vals[1] = c1;
      vals[2] = d1 + D_OFFSET;
      vals[3] = f2;
      vals[4] = g2;
      vals[5] = h2;
      vals[6] = w16;
      vals[7] = w17;
      vals[8] = r.msg_w2 + sig1(w16);
      vals[9] = W31_CONST + sig0(w16);
      vals[10] = w16 + sig0(w17);
      vals[11] = b1 + B_OFFSET;
      vals[12] = c1 + C_OFFSET;
      vals[13] = r.mid_a + A_OFFSET;
      vals[14] = w16 + W16_OFFSET;
      vals[15] = w17 + W17_OFFSET;
      tail[0] = a_new;
      tail[1] = e_new;
      tail[2] = sig1(w17) + W19_CONST;
      lanes = (lane_setting >= 3'd4) ? 4 : (lane_setting >= 3'd2) ? 2 : 1;
      n = FixedWords;
      for (int t = 0; t < LaneWords; t++) begin
         for (int k = 0; k < lanes; k++) begin
            // variant 1 flips bit 31, variant 2 bit 30, variant 3 both
            vals[n] = tail[t] ^ {k[0], k[1], 30'b0};
            n++;
         end
      end
      run_buf.delete();
      for (int i = 0; i < n; i++) begin
         item = '{pre_word: vals[i], word_index: 5'(i), last_word: (i == n - 1)};
         run_buf = {run_buf, item};
      end
   endfunction

   function automatic int pause_len();
      return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
   endfunction

   function automatic word_type rand_word();
      case ($urandom_range(0, 9))
         0: return 32'h00000000;
         1: return 32'hFFFFFFFF;
         2: return 32'h1 << $urandom_range(0, 31);
         default: return $urandom;
      endcase
   endfunction

   task automatic flag_error(input string what, input logic [31:0] want, input logic [31:0] got);
      errors++;
      if (errors <= 10)
         $display("mismatch: %s expected %h got %h", what, want, got);
   endtask

   task automatic send_header(input req_type r, input bit typed, input word_type mid_off);
      int gap;
      gap = (calm || $urandom_range(0, 99) < 60) ? 0 : pause_len();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      precalc_run(r);
      if (typed)
         run_buf[13].pre_word = mid_off;
      expected_words = {expected_words, run_buf};
   endtask

   task automatic write_lanes(input csr_type v);
      req_valid <= 1'b0;
      while (expected_words.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      csr_valid <= 1'b1;
      csr_data <= v;
      @(posedge clock);
      while (!csr_if.ready) @(posedge clock);
      csr_valid <= 1'b0;
      lane_setting = v;
   endtask

   // result side: compare each accepted word, then decide ready for the next edge
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (expected_words.size() == 0) begin
            flag_error("word with nothing expected", 32'h0, rsp_if.data.pre_word);
         end else begin
            want = expected_words.pop_front();
            if (rsp_if.data.pre_word !== want.pre_word)
               flag_error($sformatf("pre_word at index %0d", want.word_index),
                          want.pre_word, rsp_if.data.pre_word);
            if (rsp_if.data.word_index !== want.word_index)
               flag_error("word_index", 32'(want.word_index), 32'(rsp_if.data.word_index));
            if (rsp_if.data.last_word !== want.last_word)
               flag_error($sformatf("last_word at index %0d", want.word_index),
                          32'(want.last_word), 32'(rsp_if.data.last_word));
         end
      end
      if (stall_left != 0) begin
         rsp_take <= 1'b0;
         stall_left <= stall_left - 1;
      end else if (calm || $urandom_range(0, 99) < 70) begin
         rsp_take <= 1'b1;
      end else begin
         rsp_take <= 1'b0;
         stall_left <= pause_len();
      end
   end

   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
          (csr_if.valid && csr_if.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == StallLimit) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   initial begin
      req_type r;
      int sent;
      int phase_len;
      int phase;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (dir_rows[i]) begin
         if (dir_rows[i].lanes_cfg >= 0 && csr_type'(dir_rows[i].lanes_cfg) != lane_setting)
            write_lanes(csr_type'(dir_rows[i].lanes_cfg));
         send_header(dir_rows[i].hdr, dir_rows[i].typed, dir_rows[i].mid_off);
      end

      sent = 0;
      phase = 0;
      while (sent < RandomItems) begin
         write_lanes((phase == 0) ? 3'd0 : (phase == 1) ? 3'd7 : csr_type'($urandom_range(0, 7)));
         calm = ($urandom_range(0, 3) == 0);
         phase_len = $urandom_range(20, 60);
         for (int i = 0; i < phase_len && sent < RandomItems; i++) begin
            r.mid_a = rand_word();
            r.mid_b = rand_word();
            r.mid_c = rand_word();
            r.mid_d = rand_word();
            r.mid_e = rand_word();
            r.mid_f = rand_word();
            r.mid_g = rand_word();
            r.mid_h = rand_word();
            r.msg_w0 = rand_word();
            r.msg_w1 = rand_word();
            r.msg_w2 = rand_word();
            send_header(r, 1'b0, 32'h0);
            sent++;
         end
         phase++;
      end
      calm = 1'b0;
      req_valid <= 1'b0;

      while (expected_words.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
      if (errors == 0 && expected_words.size() == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule

### sha256_midstate_precalc.f
+incdir+src
src/shamp_pkg.sv
src/shamp_stream_if.sv
src/shamp_round.sv
src/shamp_final.sv
src/shamp_serializer.sv
src/sha256_midstate_precalc.sv
tb/sv/sha256_midstate_precalc_tb.sv
